// ===== design/khrd_pkg.sv =====
// Package for the key hold/repeat detector.
// Register map, reset values and the per-key update struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package khrd_pkg;

  localparam int KEY_W      = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REG_W  = 16;

  localparam logic [CFG_REG_W-1:0] HOLD_RESET   = 16'd500;
  localparam logic [CFG_REG_W-1:0] REPEAT_RESET = 16'd250;

  // Register select, taken from paddr[2] (word index)
  typedef enum logic {
    REG_HOLD_THRESHOLD  = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } khrd_reg_t;

  // Per-key state change requested by the decision logic
  typedef struct packed {
    logic begin_press;
    logic release_press;
    logic fire;
  } khrd_upd_t;

endpackage

`default_nettype wire

// ===== design/khrd_regs.sv =====
// APB-style configuration registers: hold threshold and repeat interval.
// Depends on khrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module khrd_regs
  import khrd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [CFG_REG_W-1:0]  hold_threshold_ms,
  output logic      [CFG_REG_W-1:0]  repeat_interval_ms
);

  khrd_reg_t reg_sel;
  logic      wr_en;

  // byte lanes below the word index are ignored
  assign reg_sel = khrd_reg_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_threshold_ms  <= HOLD_RESET;
      repeat_interval_ms <= REPEAT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_HOLD_THRESHOLD:  hold_threshold_ms  <= pwdata[CFG_REG_W-1:0];
        REG_REPEAT_INTERVAL: repeat_interval_ms <= pwdata[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HOLD_THRESHOLD:  prdata = CFG_DATA_W'(hold_threshold_ms);
      REG_REPEAT_INTERVAL: prdata = CFG_DATA_W'(repeat_interval_ms);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/khrd_key_state.sv =====
// Per-key state: press/fired flag flops plus start and fire time memories.
// Read at accept, written at commit, with bypass for back-to-back same key.
// Depends on khrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module khrd_key_state
  import khrd_pkg::*;
#(
  parameter int KEY_COUNT = 256,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [KEY_W-1:0]     rd_key,
  input  wire logic                 cur_valid,
  input  wire logic [KEY_W-1:0]     cur_key,
  input  wire logic                 wr_en,
  input  wire khrd_upd_t            upd,
  input  wire logic [TIME_BITS-1:0] wr_time,
  output logic                      active,
  output logic                      fired,
  output logic      [TIME_BITS-1:0] start_time,
  output logic      [TIME_BITS-1:0] fire_time
);

  localparam int IDX_W = $clog2(KEY_COUNT);

  logic [KEY_COUNT-1:0] press_active;
  logic [KEY_COUNT-1:0] has_fired;
  logic [TIME_BITS-1:0] start_mem [KEY_COUNT];
  logic [TIME_BITS-1:0] fire_mem  [KEY_COUNT];

  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     cur_idx;
  logic [TIME_BITS-1:0] start_rd;
  logic [TIME_BITS-1:0] fire_rd;
  logic                 fwd;
  logic [TIME_BITS-1:0] fwd_start;
  logic [TIME_BITS-1:0] fwd_fire;
  logic [TIME_BITS-1:0] eff_start;
  logic [TIME_BITS-1:0] eff_fire;

  assign rd_idx  = IDX_W'(rd_key);
  assign cur_idx = IDX_W'(cur_key);

  // flags: one flop per key, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      press_active <= '0;
      has_fired    <= '0;
    end else if (wr_en) begin
      if (upd.release_press) begin
        press_active[cur_idx] <= 1'b0;
      end
      if (upd.begin_press) begin
        press_active[cur_idx] <= 1'b1;
      end
      // a new press clears the fired flag unless it fires on the spot
      if (upd.begin_press || upd.fire) begin
        has_fired[cur_idx] <= upd.fire;
      end
    end
  end

  // time memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_en && upd.begin_press) begin
      start_mem[cur_idx] <= wr_time;
    end
    if (wr_en && upd.fire) begin
      fire_mem[cur_idx] <= wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      start_rd <= start_mem[rd_idx];
      fire_rd  <= fire_mem[rd_idx];
    end
  end

  // values the current item leaves behind
  assign eff_start = upd.begin_press ? wr_time : start_time;
  assign eff_fire  = upd.fire ? wr_time : fire_time;

  // bypass: the memory read of a same-key follower sees pre-write data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= cur_valid && (cur_key == rd_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_start <= eff_start;
      fwd_fire  <= eff_fire;
    end
  end

  assign start_time = fwd ? fwd_start : start_rd;
  assign fire_time  = fwd ? fwd_fire : fire_rd;
  assign active     = press_active[cur_idx];
  assign fired      = has_fired[cur_idx];

endmodule

`default_nettype wire

// ===== design/khrd_fire_logic.sv =====
// Hold/repeat decision for the item in the work stage.
// Pure combinational; depends on khrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module khrd_fire_logic
  import khrd_pkg::*;
#(
  parameter int KEY_COUNT = 256,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 cur_valid,
  input  wire logic [KEY_W-1:0]     cur_key,
  input  wire logic                 cur_down,
  input  wire logic [TIME_BITS-1:0] cur_now,
  input  wire logic                 active,
  input  wire logic                 fired,
  input  wire logic [TIME_BITS-1:0] start_time,
  input  wire logic [TIME_BITS-1:0] fire_time,
  input  wire logic [CFG_REG_W-1:0] hold_threshold_ms,
  input  wire logic [CFG_REG_W-1:0] repeat_interval_ms,
  output khrd_upd_t                 upd,
  output logic      [TIME_BITS-1:0] held
);

  logic                 in_range;
  logic                 starting;
  logic [TIME_BITS-1:0] start_eff;
  logic [TIME_BITS-1:0] since_fire;
  logic                 hold_ok;
  logic                 repeat_ok;

  // key zero and keys past the table are dropped
  assign in_range = cur_valid && (cur_key != '0) && (32'(cur_key) < 32'(KEY_COUNT));
  assign starting = in_range && cur_down && !active;

  assign start_eff  = starting ? cur_now : start_time;
  assign held       = cur_now - start_eff;
  assign since_fire = cur_now - fire_time;

  assign hold_ok   = held >= TIME_BITS'(hold_threshold_ms);
  // a fresh press has not fired yet
  assign repeat_ok = starting || !fired || (since_fire >= TIME_BITS'(repeat_interval_ms));

  assign upd.begin_press   = starting;
  assign upd.release_press = in_range && !cur_down;
  assign upd.fire          = in_range && cur_down && hold_ok && repeat_ok;

endmodule

`default_nettype wire

// ===== design/key_hold_repeat_detector.sv =====
// Key hold/repeat detector (typematic auto-repeat), top level.
// Uses khrd_pkg, khrd_regs, khrd_key_state, khrd_fire_logic.
//
// Usage:
//  - Key channel (key_valid/key_stall): one beat per key sample carrying
//    key_number, key_down and now_ms. Key 0 and keys >= KEY_COUNT are dropped.
//  - Held channel (held_valid/held_stall): one beat per firing, carrying
//    held_key and held_ms (time since the press began, wrapped).
//  - Config: APB-style, hold threshold at 0x0, repeat interval at 0x4.
//    Write only while no sample is in flight.
// Timing:
//  - Accepted sample: per-key state is read into the work stage, the
//    decision is made there, and a firing is registered into the result
//    register, which drives held_valid.
//  - One sample per cycle sustained unless held_stall backs up the block;
//    same-key back-to-back samples bypass the time memories' registered reads.
//  - held_stall holds the result register and the work stage waits behind
//    it; key_stall rises when both hold an item and held_stall is high.
// Reset: all press/fired flags clear at once (no clearing pass); time
//  memories are not cleared; registers return to 500 ms and 250 ms.
`timescale 1ns / 1ps
`default_nettype none

module key_hold_repeat_detector
  import khrd_pkg::*;
#(
  parameter int KEY_COUNT = 256,
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // key sample channel
  input  wire logic                  key_valid,
  output logic                       key_stall,
  input  wire logic [KEY_W-1:0]      key_number,
  input  wire logic                  key_down,
  input  wire logic [31:0]           now_ms,
  // hold event channel
  output logic                       held_valid,
  input  wire logic                  held_stall,
  output logic      [KEY_W-1:0]      held_key,
  output logic      [31:0]           held_ms,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [CFG_REG_W-1:0] hold_threshold_ms;
  logic [CFG_REG_W-1:0] repeat_interval_ms;

  // work stage registers
  logic                 s1_valid;
  logic [KEY_W-1:0]     s1_key;
  logic                 s1_down;
  logic [TIME_BITS-1:0] s1_now;

  logic                 key_accept;
  logic                 s1_adv;

  logic                 active;
  logic                 fired;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] fire_time;
  khrd_upd_t            upd;
  logic [TIME_BITS-1:0] held;

  khrd_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .hold_threshold_ms  (hold_threshold_ms),
    .repeat_interval_ms (repeat_interval_ms)
  );

  // work stage moves on whenever the result register is free or draining
  assign s1_adv     = s1_valid && (!held_valid || !held_stall);
  assign key_stall  = s1_valid && !s1_adv;
  assign key_accept = key_valid && !key_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_accept) begin
      s1_key  <= key_number;
      s1_down <= key_down;
      s1_now  <= TIME_BITS'(now_ms);
    end
  end

  khrd_key_state #(
    .KEY_COUNT (KEY_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_key_state (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (key_accept),
    .rd_key     (key_number),
    .cur_valid  (s1_valid),
    .cur_key    (s1_key),
    .wr_en      (s1_adv),
    .upd        (upd),
    .wr_time    (s1_now),
    .active     (active),
    .fired      (fired),
    .start_time (start_time),
    .fire_time  (fire_time)
  );

  khrd_fire_logic #(
    .KEY_COUNT (KEY_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_fire_logic (
    .cur_valid          (s1_valid),
    .cur_key            (s1_key),
    .cur_down           (s1_down),
    .cur_now            (s1_now),
    .active             (active),
    .fired              (fired),
    .start_time         (start_time),
    .fire_time          (fire_time),
    .hold_threshold_ms  (hold_threshold_ms),
    .repeat_interval_ms (repeat_interval_ms),
    .upd                (upd),
    .held               (held)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s1_adv) begin
      held_valid <= upd.fire;
    end else if (!held_stall) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && upd.fire) begin
      held_key <= s1_key;
      held_ms  <= 32'(held);
    end
  end

endmodule

`default_nettype wire

// ===== design/khrd_checker.sv =====
// Port-level checks for key_hold_repeat_detector, attached by bind.
// Depends on khrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module khrd_checker
  import khrd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  held_valid,
  input wire logic                  held_stall,
  input wire logic [KEY_W-1:0]      held_key,
  input wire logic [31:0]           held_ms,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [CFG_DATA_W-1:0] pwdata,
  input wire logic [CFG_DATA_W-1:0] prdata,
  input wire logic                  pready
);

  // stalled result beat holds
  a_held_hold: assert property (@(posedge clk) disable iff (rst)
    held_valid && held_stall |=> held_valid && $stable(held_key) && $stable(held_ms))
    else $error("held beat changed under stall");

  // key zero never fires
  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> held_key != '0)
    else $error("event for key zero");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !held_valid)
    else $error("result valid after reset");

  // threshold write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[2] == REG_HOLD_THRESHOLD)
    |=> (paddr[2] != REG_HOLD_THRESHOLD) ||
        (prdata[CFG_REG_W-1:0] == $past(pwdata[CFG_REG_W-1:0])))
    else $error("threshold readback mismatch");

endmodule

bind key_hold_repeat_detector khrd_checker u_khrd_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for key_hold_repeat_detector: hold/repeat event prediction and checking.
// Needs khrd_pkg and the detector RTL; it is self-contained otherwise.
`timescale 1ns / 1ps

module tb_top;
  import khrd_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      ms;
  } hold_event_t;

  // Tracks per-key press state, predicts the hold events and checks what the block emits.
  class hold_scoreboard;
    bit [CFG_REG_W-1:0] threshold;
    bit [CFG_REG_W-1:0] interval;
    bit                 pressed  [256];
    bit [31:0]          press_at [256];
    bit                 fired    [256];
    bit [31:0]          fired_at [256];
    hold_event_t        due_events[$];
    int                 errors;
    int                 samples;
    int                 events_seen;

    function new();
      threshold = HOLD_RESET;
      interval  = REPEAT_RESET;
      foreach (pressed[i]) begin
        pressed[i]  = 1'b0;
        fired[i]    = 1'b0;
        press_at[i] = '0;
        fired_at[i] = '0;
      end
    endfunction

    function void set_reg(khrd_reg_t r, bit [CFG_REG_W-1:0] v);
      if (r == REG_HOLD_THRESHOLD) threshold = v;
      else interval = v;
    endfunction

    function bit [CFG_REG_W-1:0] reg_value(khrd_reg_t r);
      return (r == REG_HOLD_THRESHOLD) ? threshold : interval;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // One accepted key beat: update press state, queue an event if it fires.
    function void note_sample(bit [KEY_W-1:0] k, bit d, bit [31:0] t);
      bit [31:0]   held;
      bit [31:0]   since_fire;
      hold_event_t ev;
      samples++;
      if (k == 0) return;
      if (!d) begin
        pressed[k] = 1'b0;
        return;
      end
      if (!pressed[k]) begin
        pressed[k]  = 1'b1;
        press_at[k] = t;
        fired[k]    = 1'b0;
      end
      held = t - press_at[k];
      if (held < threshold) return;
      since_fire = t - fired_at[k];
      if (fired[k] && since_fire < interval) return;
      fired[k]    = 1'b1;
      fired_at[k] = t;
      ev.key = k;
      ev.ms  = held;
      due_events.push_back(ev);
    endfunction

    // One accepted held beat against the oldest queued event.
    task check_result(logic [KEY_W-1:0] k, logic [31:0] ms);
      hold_event_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected event key %0d held %0d", k, ms));
        return;
      end
      want = due_events.pop_front();
      events_seen++;
      if (k !== want.key)
        report($sformatf("held_key %0d, want %0d", k, want.key));
      if (ms !== want.ms)
        report($sformatf("held_ms %0d, want %0d (key %0d)", ms, want.ms, want.key));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  key_valid  = 1'b0;
  logic                  key_stall;
  logic [KEY_W-1:0]      key_number = '0;
  logic                  key_down   = 1'b0;
  logic [31:0]           now_ms     = '0;
  logic                  held_valid;
  logic                  held_stall = 1'b0;
  logic [KEY_W-1:0]      held_key;
  logic [31:0]           held_ms;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  hold_scoreboard sb = new();

  // knobs shared by the stimulus and receiver processes
  int idle_pct  = 0;    // sender: chance per cycle of leaving key_valid low
  int stall_pct = 0;    // receiver: chance per cycle of raising held_stall
  int hold_off  = 0;    // receiver: cycles of forced stall still to go
  int settings  = 0;    // register settings exercised, for the summary

  always #5 clk = ~clk;

  key_hold_repeat_detector i_dut (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_number (key_number),
    .key_down   (key_down),
    .now_ms     (now_ms),
    .held_valid (held_valid),
    .held_stall (held_stall),
    .held_key   (held_key),
    .held_ms    (held_ms),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // ---------------------------------------------------------------------------
  // Monitors: a beat moves on an edge with valid high and stall low.
  // Values read here are the pre-edge ones, since everything is driven by NBA.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (key_valid && !key_stall) sb.note_sample(key_number, key_down, now_ms);
      if (held_valid && !held_stall) sb.check_result(held_key, held_ms);
    end
  end

  // Receiver: random stall, or a counted hold-off that lets the block back up
  // until key_stall rises.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        held_stall <= 1'b1;
        hold_off   -= 1;
      end else begin
        held_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one key beat, with random gaps ahead of it; return once accepted.
  // key_valid stays high afterwards so back-to-back beats need no toggle.
  task send_sample(logic [KEY_W-1:0] k, logic d, logic [31:0] t);
    while ($urandom_range(99) < idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid  <= 1'b1;
    key_number <= k;
    key_down   <= d;
    now_ms     <= t;
    @(posedge clk);
    while (key_stall) @(posedge clk);
  endtask

  // Stop offering, wait for every queued event, then cover the pipeline
  // latency in case the last beats fired nothing.
  task drain();
    key_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB read of one register, compared against the tracked value.
  task cfg_readback(khrd_reg_t r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_REG_W-1:0] !== sb.reg_value(r))
      sb.report($sformatf("%s reads %0d, want %0d", r.name(),
                          prdata[CFG_REG_W-1:0], sb.reg_value(r)));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // APB write (setup + access); junk in the upper data bits must be dropped.
  task cfg_write(khrd_reg_t r, logic [CFG_REG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {16'($urandom()), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk);
    cfg_readback(r);
  endtask

  // Drains the block first, so both writes are made with it idle.
  task program_limits(int hold_ms, int repeat_ms);
    drain();
    cfg_write(REG_HOLD_THRESHOLD, hold_ms[CFG_REG_W-1:0]);
    cfg_write(REG_REPEAT_INTERVAL, repeat_ms[CFG_REG_W-1:0]);
    settings++;
  endtask

  // Random traffic. Most beats follow a small set of live keys on a rising
  // tick, stepped in proportion to the limits so presses cross the threshold
  // and repeat; the rest is arbitrary-key noise at random or nearby ticks.
  task random_phase(int n, int hold_ms, int repeat_ms, int send_idle, int recv_stall,
                    logic [31:0] start_tick, bit squeeze);
    logic [KEY_W-1:0] live_keys [4];
    logic [31:0]      tick;
    int               span;
    int               pick;
    program_limits(hold_ms, repeat_ms);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    foreach (live_keys[j]) live_keys[j] = KEY_W'($urandom_range(255, 1));
    tick = start_tick;
    span = ((hold_ms > repeat_ms) ? hold_ms : repeat_ms) / 6 + 2;
    // long receiver hold-off while the sender keeps pushing
    if (squeeze) hold_off = 300;
    for (int i = 0; i < n; i++) begin
      // sender pause mid-phase until every event is back
      if (i == n / 2) drain();
      pick = $urandom_range(99);
      if (pick < 80) begin
        tick += $urandom_range(span);
        send_sample(live_keys[2'($urandom_range(3))], $urandom_range(99) < 88, tick);
      end else if (pick < 90) begin
        live_keys[2'($urandom_range(3))] = KEY_W'($urandom_range(255, 1));
        send_sample(KEY_W'($urandom_range(255)), 1'($urandom_range(1)), $urandom());
      end else begin
        send_sample(KEY_W'($urandom_range(255)), 1'($urandom_range(1)),
                    tick + $urandom_range(span));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of both registers
    cfg_readback(REG_HOLD_THRESHOLD);
    cfg_readback(REG_REPEAT_INTERVAL);
    settings++;

    // Directed, at 500 / 250: key zero ignored, first firing exactly at the
    // threshold, repeat exactly at the interval, release and re-press,
    // hold across the tick wrap.
    send_sample(8'd0,   1'b1, 32'd0);
    send_sample(8'd0,   1'b0, 32'hFFFF_FFFF);
    send_sample(8'd255, 1'b1, 32'd1000);
    send_sample(8'd255, 1'b1, 32'd1499);
    send_sample(8'd255, 1'b1, 32'd1500);
    send_sample(8'd255, 1'b1, 32'd1749);
    send_sample(8'd255, 1'b1, 32'd1750);
    send_sample(8'd255, 1'b0, 32'd1800);
    send_sample(8'd255, 1'b1, 32'd1900);
    send_sample(8'd255, 1'b1, 32'd2400);
    send_sample(8'd1,   1'b1, 32'hFFFF_FF00);
    send_sample(8'd1,   1'b1, 32'h0000_0100);
    send_sample(8'd128, 1'b1, 32'h5555_5555);
    send_sample(8'd127, 1'b0, 32'hAAAA_AAAA);
    send_sample(8'd1,   1'b0, 32'd0);

    // zero limits: fires on the press beat itself and on every later one
    program_limits(0, 0);
    send_sample(8'd200, 1'b1, 32'd7);
    send_sample(8'd200, 1'b1, 32'd7);
    send_sample(8'd200, 1'b0, 32'd8);

    // top threshold, zero interval: fires at 65535 and then every beat
    program_limits(65535, 0);
    send_sample(8'd3, 1'b1, 32'd0);
    send_sample(8'd3, 1'b1, 32'd65534);
    send_sample(8'd3, 1'b1, 32'd65535);
    send_sample(8'd3, 1'b1, 32'hFFFF_FFFF);

    // random phases cycle through the idle/stall profiles
    random_phase(240, 0, 0, 0, 0, $urandom(), 1'b1);
    random_phase(240, 65535, 65535, 85, 0, $urandom(), 1'b0);
    random_phase(240, $urandom_range(300, 1), $urandom_range(150, 1), 0, 85,
                 $urandom(), 1'b0);
    random_phase(240, 65535, 0, 35, 35, $urandom(), 1'b0);
    random_phase(240, 0, 65535, 0, 0, 32'hFFFF_0000, 1'b0);
    random_phase(240, $urandom_range(65535), $urandom_range(65535), 85, 0,
                 $urandom(), 1'b0);
    random_phase(240, $urandom_range(300, 1), $urandom_range(150, 1), 0, 85,
                 32'hFFFF_FF00, 1'b1);
    random_phase(240, 500, 250, 35, 35, $urandom(), 1'b0);

    stall_pct = 0;
    drain();
    repeat (10) @(posedge clk);
    if (sb.due_events.size() != 0)
      sb.report($sformatf("%0d events never arrived", sb.due_events.size()));

    $display("Run covered %0d key beats under %0d register settings, %0d hold events checked.",
             sb.samples, settings, sb.events_seen);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d events outstanding", sb.due_events.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
